### design/assert_macros.svh
// Shared assertion forms for the scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MBPS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequent in the same cycle.
`define MBPS_ASSERT_IMPLY(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Check that a condition implies a consequent in the next cycle.
`define MBPS_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### design/mbps_pkg.sv
package mbps_pkg;

  localparam int PatternMax = 16;
  localparam int PosBits    = 32;
  localparam int AddrW      = 64;
  localparam int LenW       = 5;
  localparam int LenCap     = (PatternMax < 16) ? PatternMax : 16;
  localparam int LimitMax   = 4096;
  localparam int CountW     = 13;
  localparam int IdxW       = 12;
  localparam int MaskW      = 16;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = 2;
  localparam int FifoCntW   = 3;
  localparam int OutDataW   = 96;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_ADDRESS,
    REG_PATTERN_LOW,
    REG_PATTERN_HIGH,
    REG_COMPARE_MASK,
    REG_PATTERN_LENGTH,
    REG_FIND_ALL,
    REG_RESULT_LIMIT
  } cfg_reg_t;

  typedef enum logic {
    KIND_MATCH,
    KIND_DONE
  } item_kind_t;

  typedef enum logic [1:0] {
    STATUS_FOUND,
    STATUS_ABSENT,
    STATUS_SHORT
  } scan_status_t;

  typedef struct packed {
    logic [7:0] pat;
    logic       care;
  } cell_cfg_t;

  typedef struct packed {
    item_kind_t          kind;
    logic [AddrW-1:0]    addr;
    logic [IdxW-1:0]     idx;
    scan_status_t        status;
    logic [CountW-1:0]   total;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_ctrl_t;

endpackage

### design/mbps_cell.sv
module mbps_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic                clear,
  input  logic [7:0]          din,
  input  mbps_pkg::cell_cfg_t cfg,
  output logic [7:0]          dout,
  output logic                hit
);
  import mbps_pkg::*;

  cell_cfg_t  cfg_q;
  logic [7:0] data;

  always_ff @(posedge clk) begin
    cfg_q <= cfg;
    if (rst) begin
      data <= '0;
    end else if (shift) begin
      data <= clear ? 8'd0 : din;
    end
  end

  assign dout = data;
  assign hit  = !cfg_q.care || (din == cfg_q.pat);

endmodule

### design/mbps_out_fifo.sv
`include "assert_macros.svh"

module mbps_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  mbps_pkg::push_ctrl_t push,
  input  mbps_pkg::out_item_t  item0,
  input  mbps_pkg::out_item_t  item1,
  input  logic                 pop,
  output mbps_pkg::out_item_t  head,
  output logic                 nonempty,
  output logic                 space2
);
  import mbps_pkg::*;

  out_item_t             mem [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr;
  logic [FifoPtrW-1:0]   rd_ptr;
  logic [FifoCntW-1:0]   count;
  logic [FifoCntW-1:0]   count_next;
  logic [FifoPtrW-1:0]   wr_ptr_next;

  always_comb begin
    count_next  = count + FifoCntW'(push.first) + FifoCntW'(push.second)
                  - FifoCntW'(pop);
    wr_ptr_next = wr_ptr + FifoPtrW'(push.first) + FifoPtrW'(push.second);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr] <= item0;
    end
    if (push.second) begin
      mem[wr_ptr + FifoPtrW'(1)] <= item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= rd_ptr + FifoPtrW'(1);
      end
      count <= count_next;
    end
  end

  assign head     = mem[rd_ptr];
  assign nonempty = (count != '0);
  assign space2   = (count <= FifoCntW'(FifoDepth - 2));

  `MBPS_ASSERT(a_count_bound, clk, rst, count <= FifoCntW'(FifoDepth), "fifo count overflow")
  `MBPS_ASSERT_IMPLY(a_push_order, clk, rst, push.second, push.first, "second push without first")
  `MBPS_ASSERT_IMPLY(a_pop_nonempty, clk, rst, pop, count != '0, "pop from empty fifo")

endmodule

### design/masked_byte_pattern_scanner.sv
// A result transaction is written into the output queue when the byte that causes it is taken.
// Throughput: one byte per cycle while input is not held off; a 16-cell shift-compare row checks
// every window in that cycle. A byte that yields both a match and an end-of-scan transaction
// fills two slots of the four-entry output queue; input is held off until two slots are free.
// Reset (synchronous, active high) clears the window, counters and queue and loads the
// register defaults. Input is held off after reset and after each register write.
`include "assert_macros.svh"

module masked_byte_pattern_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_en,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // data_byte[7:0]
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mbps_pkg::OutDataW-1:0] m_tdata,  // match_address[63:0], result_index[75:64],
                                                  // scan_status[77:76], total_matches[90:78]
  output logic                          m_tuser,  // item_kind[0]
  output logic                          m_tlast
);
  import mbps_pkg::*;

  logic [AddrW-1:0]   start_address;
  logic [63:0]        pattern_low;
  logic [63:0]        pattern_high;
  logic [MaskW-1:0]   compare_mask;
  logic [LenW-1:0]    pattern_length;
  logic               find_all;
  logic [CountW-1:0]  result_limit;
  logic               cfg_hold;

  logic [LenW-1:0]    eff_len;
  logic [CountW-1:0]  eff_limit;
  logic [AddrW-1:0]   base0;
  logic [AddrW-1:0]   base1;

  logic [PosBits-1:0] pos;
  logic [PosBits-1:0] pos_next;
  logic [CountW-1:0]  match_count;
  logic [CountW-1:0]  count_next;
  logic               stopped;
  logic               stopped_next;

  logic               s_accept;
  logic               pos_sat;
  logic               full;
  logic               hit;
  logic [AddrW-1:0]   match_addr;
  logic [127:0]       pat_vec;
  logic [PatternMax-1:0] cell_hit;
  logic [7:0]         chain [PatternMax+1];

  push_ctrl_t         push;
  out_item_t          match_item;
  out_item_t          done_item;
  out_item_t          item0;
  out_item_t          item1;
  out_item_t          head;
  logic               nonempty;
  logic               space2;
  scan_status_t       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address  <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
      compare_mask   <= '1;
      pattern_length <= LenW'(1);
      find_all       <= 1'b0;
      result_limit   <= CountW'(256);
    end else if (cfg_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_ADDRESS:  start_address  <= cfg_data;
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_COMPARE_MASK:   compare_mask   <= cfg_data[MaskW-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LenW-1:0];
        REG_FIND_ALL:       find_all       <= cfg_data[0];
        REG_RESULT_LIMIT:   result_limit   <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  // hold input while the registered cell settings and bases catch up
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_hold <= 1'b1;
    end else begin
      cfg_hold <= cfg_en;
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LenW'(1);
    end else if (pattern_length > LenW'(LenCap)) begin
      eff_len = LenW'(LenCap);
    end else begin
      eff_len = pattern_length;
    end
    if (result_limit == '0) begin
      eff_limit = CountW'(1);
    end else if (result_limit > CountW'(LimitMax)) begin
      eff_limit = CountW'(LimitMax);
    end else begin
      eff_limit = result_limit;
    end
  end

  // window start address = start - len + position
  always_ff @(posedge clk) begin
    base0 <= start_address - AddrW'(eff_len);
    base1 <= start_address - AddrW'(eff_len) + AddrW'(1);
  end

  assign pat_vec     = {pattern_high, pattern_low};
  assign s_accept    = s_tvalid && s_tready;
  assign s_tready    = space2 && !cfg_hold;
  assign chain[0]    = s_tdata;

  for (genvar j = 0; j < PatternMax; j++) begin : g_cell
    logic [LenW-1:0] sel_full;
    logic [3:0]      sel;
    cell_cfg_t       ccfg;

    always_comb begin
      sel_full  = eff_len - LenW'(j + 1);
      sel       = sel_full[3:0];
      ccfg.pat  = pat_vec[{sel, 3'b000} +: 8];
      ccfg.care = (LenW'(j) < eff_len) && compare_mask[sel];
    end

    mbps_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (s_accept),
      .clear (s_tlast),
      .din   (chain[j]),
      .cfg   (ccfg),
      .dout  (chain[j+1]),
      .hit   (cell_hit[j])
    );
  end

  always_comb begin
    pos_sat      = (pos == '1);
    pos_next     = pos_sat ? pos : pos + PosBits'(1);
    match_addr   = pos_sat ? base0 + AddrW'(pos) : base1 + AddrW'(pos);
    full         = (pos_next >= PosBits'(eff_len));
    hit          = (&cell_hit) && full && !stopped;
    count_next   = match_count + CountW'(hit);
    stopped_next = stopped || (hit && (!find_all || (count_next >= eff_limit)));

    if (count_next != '0) begin
      status = STATUS_FOUND;
    end else if (!full) begin
      status = STATUS_SHORT;
    end else begin
      status = STATUS_ABSENT;
    end

    match_item.kind   = KIND_MATCH;
    match_item.addr   = match_addr;
    match_item.idx    = match_count[IdxW-1:0];
    match_item.status = STATUS_FOUND;
    match_item.total  = count_next;
    match_item.last   = 1'b0;

    done_item.kind    = KIND_DONE;
    done_item.addr    = '0;
    done_item.idx     = '0;
    done_item.status  = status;
    done_item.total   = count_next;
    done_item.last    = 1'b1;

    item0       = hit ? match_item : done_item;
    item1       = done_item;
    push.first  = s_accept && (hit || s_tlast);
    push.second = s_accept && hit && s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      match_count <= '0;
      stopped     <= 1'b0;
    end else if (s_accept) begin
      if (s_tlast) begin
        pos         <= '0;
        match_count <= '0;
        stopped     <= 1'b0;
      end else begin
        pos         <= pos_next;
        match_count <= count_next;
        stopped     <= stopped_next;
      end
    end
  end

  mbps_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item0    (item0),
    .item1    (item1),
    .pop      (m_tvalid && m_tready),
    .head     (head),
    .nonempty (nonempty),
    .space2   (space2)
  );

  assign m_tvalid = nonempty;
  assign m_tdata  = {5'd0, head.total, head.status, head.idx, head.addr};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  `MBPS_ASSERT(a_count_limit, clk, rst, match_count <= CountW'(LimitMax), "match count past limit")
  `MBPS_ASSERT_IMPLY(a_no_hit_stopped, clk, rst, stopped, !hit, "match reported after stop")
  `MBPS_ASSERT_NEXT(a_scan_clear, clk, rst, s_accept && s_tlast, pos == '0 && match_count == '0 && !stopped, "scan state not cleared")
  `MBPS_ASSERT_IMPLY(a_done_last, clk, rst, m_tvalid && (m_tuser == KIND_DONE), m_tlast, "end-of-scan transaction without tlast")

endmodule

### dv/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner;
  import mbps_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int RandomPhases  = 10;
  localparam int BytesPerPhase = 90;
  localparam int LongScanBytes = 120;
  localparam int MaxLogged     = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } region_byte_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                cfg_en   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  masked_byte_pattern_scanner dut (.*);

  // register shadow
  logic [AddrW-1:0]  start_addr_q = '0;
  logic [127:0]      pattern_q    = '0;
  logic [MaskW-1:0]  mask_q       = '1;
  logic [LenW-1:0]   len_q        = LenW'(1);
  logic              find_all_q   = 1'b0;
  logic [CountW-1:0] limit_q      = CountW'(256);

  // scan state
  logic [7:0]        window_q [PatternMax] = '{default: '0};
  logic [PosBits-1:0] position_q = '0;
  logic [CountW-1:0] found_q     = '0;
  logic              stopped_q   = 1'b0;

  region_byte_t pending_bytes[$];
  out_item_t    expected_items[$];
  region_byte_t drive_byte;
  out_item_t    got_item;
  out_item_t    want_item;
  int           bytes_in_flight  = 0;
  int           errors           = 0;
  int           sender_idle_pct  = 0;
  int           receiver_stall_pct = 0;
  int           cycle_count      = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_len();
    int l = len_q;
    if (l == 0) l = 1;
    if (l > LenCap) l = LenCap;
    return l;
  endfunction

  function automatic int eff_limit();
    int m = limit_q;
    if (m == 0) m = 1;
    if (m > LimitMax) m = LimitMax;
    return m;
  endfunction

  function automatic logic window_hit(int l);
    for (int i = 0; i < l; i++) begin
      if (mask_q[i] && window_q[l-1-i] != pattern_q[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic string describe(out_item_t r);
    return $sformatf("kind=%0d addr=%h idx=%0d status=%0d total=%0d last=%0d",
                     r.kind, r.addr, r.idx, r.status, r.total, r.last);
  endfunction

  task automatic scan_byte(logic [7:0] b, logic last);
    int        l;
    out_item_t item;
    l = eff_len();
    for (int i = PatternMax - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = b;
    if (position_q != '1) position_q++;
    if (!stopped_q && position_q >= l && window_hit(l)) begin
      item.kind   = KIND_MATCH;
      item.addr   = start_addr_q + AddrW'(position_q) - AddrW'(l);
      item.idx    = found_q[IdxW-1:0];
      item.status = STATUS_FOUND;
      found_q++;
      item.total  = found_q;
      item.last   = 1'b0;
      expected_items.push_back(item);
      if (!find_all_q || found_q >= eff_limit()) stopped_q = 1'b1;
    end
    if (last) begin
      item.kind = KIND_DONE;
      item.addr = '0;
      item.idx  = '0;
      if (found_q != 0) item.status = STATUS_FOUND;
      else if (position_q < l) item.status = STATUS_SHORT;
      else item.status = STATUS_ABSENT;
      item.total = found_q;
      item.last  = 1'b1;
      expected_items.push_back(item);
      window_q   = '{default: '0};
      position_q = '0;
      found_q    = '0;
      stopped_q  = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        drive_byte = pending_bytes.pop_front();
        s_tdata  <= drive_byte.data;
        s_tlast  <= drive_byte.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scan_byte(s_tdata, s_tlast);
        bytes_in_flight--;
      end
      if (m_tvalid && m_tready) begin
        got_item.kind   = item_kind_t'(m_tuser);
        got_item.addr   = m_tdata[63:0];
        got_item.idx    = m_tdata[75:64];
        got_item.status = scan_status_t'(m_tdata[77:76]);
        got_item.total  = m_tdata[90:78];
        got_item.last   = m_tlast;
        if (expected_items.size() == 0) begin
          errors++;
          if (errors <= MaxLogged)
            $display("%0t: expected nothing, got %s", $time, describe(got_item));
        end else begin
          want_item = expected_items.pop_front();
          if (got_item.kind !== want_item.kind || got_item.addr !== want_item.addr ||
              got_item.idx !== want_item.idx || got_item.status !== want_item.status ||
              got_item.total !== want_item.total || got_item.last !== want_item.last) begin
            errors++;
            if (errors <= MaxLogged)
              $display("%0t: expected %s, got %s", $time, describe(want_item),
                       describe(got_item));
          end
        end
      end
      m_tready <= $urandom_range(99) >= receiver_stall_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("masked_byte_pattern_scanner: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_en   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      REG_START_ADDRESS:  start_addr_q = value;
      REG_PATTERN_LOW:    pattern_q[63:0] = value;
      REG_PATTERN_HIGH:   pattern_q[127:64] = value;
      REG_COMPARE_MASK:   mask_q = value[MaskW-1:0];
      REG_PATTERN_LENGTH: len_q = value[LenW-1:0];
      REG_FIND_ALL:       find_all_q = value[0];
      REG_RESULT_LIMIT:   limit_q = value[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic send(logic [7:0] b, logic last);
    pending_bytes.push_back('{data: b, last: last});
    bytes_in_flight++;
  endtask

  task automatic wait_idle();
    while (bytes_in_flight != 0 || expected_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle(int mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
      default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
    endcase
  endtask

  task automatic random_config();
    logic [63:0]       noise;
    logic [MaskW-1:0]  m;
    logic [LenW-1:0]   len;
    logic [CountW-1:0] lim;
    int                r;
    noise = {$urandom, $urandom};
    if ($urandom_range(3) == 0)
      write_reg(REG_START_ADDRESS, {56'hFF_FFFF_FFFF_FFFF, noise[7:0]});
    else
      write_reg(REG_START_ADDRESS, {$urandom, $urandom});
    write_reg(REG_PATTERN_LOW, {$urandom, $urandom});
    write_reg(REG_PATTERN_HIGH, {$urandom, $urandom});
    r = $urandom_range(3);
    case (r)
      0: m = '1;
      1: m = MaskW'($urandom);
      2: m = MaskW'($urandom | $urandom);
      default: m = MaskW'($urandom & $urandom);
    endcase
    write_reg(REG_COMPARE_MASK, {noise[63:MaskW], m});
    r = $urandom_range(19);
    if (r == 0) len = '0;
    else if (r <= 2) len = LenW'($urandom_range(17, 31));
    else len = LenW'($urandom_range(1, 16));
    write_reg(REG_PATTERN_LENGTH, {noise[63:LenW], len});
    write_reg(REG_FIND_ALL, {noise[63:1], $urandom_range(3) != 0});
    r = $urandom_range(9);
    if (r == 0) lim = '0;
    else if (r == 1) lim = CountW'($urandom_range(4097, 8191));
    else if (r == 2) lim = CountW'(LimitMax);
    else lim = CountW'($urandom_range(1, 6));
    write_reg(REG_RESULT_LIMIT, {noise[63:CountW], lim});
  endtask

  task automatic send_region(output int rlen);
    logic [7:0] region [64];
    logic [7:0] fill;
    int         l;
    int         plants;
    int         at;
    l = eff_len();
    rlen = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    fill = 8'($urandom);
    for (int i = 0; i < rlen; i++) region[i] = fill;
    if ($urandom_range(7) != 0)
      for (int i = 0; i < rlen; i++) region[i] = 8'($urandom);
    if (rlen >= l) begin
      plants = $urandom_range(0, 3);
      for (int p = 0; p < plants; p++) begin
        at = $urandom_range(0, rlen - l);
        for (int j = 0; j < l; j++)
          if (mask_q[j]) region[at+j] = pattern_q[8*j +: 8];
      end
    end
    for (int i = 0; i < rlen; i++) send(region[i], i == rlen - 1);
  endtask

  initial begin
    int sent;
    int rlen;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults: one-byte pattern 0x00, stop at first hit
    set_idle(0);
    send(8'h00, 1'b1);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b0);
    send(8'h00, 1'b1);
    send(8'hFF, 1'b1);
    wait_idle();

    // four-byte pattern with a wildcard, address wrap, short region
    set_idle(1);
    write_reg(REG_START_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_4433_2211);
    write_reg(REG_COMPARE_MASK, 64'h0000_0000_0000_000B);
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    write_reg(REG_FIND_ALL, 64'd1);
    write_reg(REG_RESULT_LIMIT, 64'd3);
    send(8'h11, 1'b0);
    send(8'h22, 1'b1);
    send(8'h11, 1'b0);
    send(8'h22, 1'b0);
    send(8'hAA, 1'b0);
    send(8'h44, 1'b0);
    send(8'h11, 1'b0);
    send(8'h22, 1'b0);
    send(8'h55, 1'b0);
    send(8'h44, 1'b1);
    wait_idle();

    // zero length and zero limit
    set_idle(2);
    write_reg(REG_START_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_005A);
    write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_COMPARE_MASK, 64'h0000_0000_0000_0001);
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    write_reg(REG_RESULT_LIMIT, 64'd0);
    send(8'h5A, 1'b0);
    send(8'h5A, 1'b1);
    wait_idle();

    // every byte hits; limit above range does not stop the scan early
    set_idle(3);
    write_reg(REG_START_ADDRESS, 64'd0);
    write_reg(REG_COMPARE_MASK, 64'd0);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_RESULT_LIMIT, 64'h1FFF);
    for (int i = 0; i < LongScanBytes; i++) send(8'($urandom), i == LongScanBytes - 1);
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      set_idle(p);
      random_config();
      sent = 0;
      while (sent < BytesPerPhase) begin
        send_region(rlen);
        sent += rlen;
      end
      wait_idle();
    end

    if (errors == 0 && expected_items.size() == 0) begin
      $display("masked_byte_pattern_scanner: match");
    end else begin
      $display("masked_byte_pattern_scanner: mismatch");
    end
    $finish;
  end

endmodule
